/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers; define NO_ASSERTIONS to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, expr, msg)

`endif

`endif

/* design/fbcbm_pkg.sv */
// ----------------------------------------------------------------------------
// fbcbm_pkg
// Shared types, widths and scoring functions of the framebuffer matcher.
// ----------------------------------------------------------------------------
package fbcbm_pkg;

  localparam int CHANNEL_BITS     = 8;
  localparam int MAX_CANDIDATES_DEF = 1024;

  localparam int COLOR_W   = 24;
  localparam int ACCUM_W   = 32;
  localparam int SCALAR_W  = 8;
  localparam int REQ_W     = 9;
  localparam int FLAGS_W   = 3;
  localparam int IDX_W     = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SQ_W          = 2 * CHANNEL_BITS;
  localparam int SQ8_W         = 2 * SCALAR_W;
  localparam int MISS_W        = 9;
  localparam int COLOR_COST_W  = SQ_W + 2;
  localparam int EXTRA_COST_W  = SQ_W + 4;

  localparam int FLAG_STEREO = 0;
  localparam int FLAG_DOUBLE = 1;
  localparam int FLAG_SRGB   = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR   = 3'd0,
    REG_ACCUM   = 3'd1,
    REG_ALPHA   = 3'd2,
    REG_DEPTH   = 3'd3,
    REG_STENCIL = 3'd4,
    REG_SAMPLES = 3'd5,
    REG_AUX     = 3'd6,
    REG_FLAGS   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [COLOR_W-1:0]  color;
    logic [ACCUM_W-1:0]  accum;
    logic [REQ_W-1:0]    alpha;
    logic [REQ_W-1:0]    depth;
    logic [REQ_W-1:0]    stencil;
    logic [REQ_W-1:0]    samples;
    logic [REQ_W-1:0]    aux;
    logic [FLAGS_W-1:0]  flags;
  } cfg_t;

  typedef struct packed {
    logic [COLOR_W-1:0]  color;
    logic [ACCUM_W-1:0]  accum;
    logic [SCALAR_W-1:0] alpha;
    logic [SCALAR_W-1:0] depth;
    logic [SCALAR_W-1:0] stencil;
    logic [SCALAR_W-1:0] samples;
    logic [SCALAR_W-1:0] aux;
    logic [FLAGS_W-1:0]  flags;
    logic                last;
  } cand_t;

  typedef struct packed {
    logic                    skip;
    logic [MISS_W-1:0]       missing;
    logic [COLOR_COST_W-1:0] color;
    logic [EXTRA_COST_W-1:0] extra;
    logic                    last;
  } score_t;

  // Squared difference of two packed sub-fields.
  function automatic logic [SQ_W-1:0] sq_diff(input logic [CHANNEL_BITS-1:0] a,
                                               input logic [CHANNEL_BITS-1:0] b);
    logic [CHANNEL_BITS-1:0] d;
    d = (a > b) ? a - b : b - a;
    return SQ_W'(d) * SQ_W'(d);
  endfunction

  // A sub-field request of all ones is a don't care.
  function automatic logic [SQ_W-1:0] packed_term(input logic [CHANNEL_BITS-1:0] want,
                                                   input logic [CHANNEL_BITS-1:0] have);
    return (want == '1) ? '0 : sq_diff(want, have);
  endfunction

  // A negative scalar request is a don't care.
  function automatic logic [SQ8_W-1:0] scalar_term(input logic [REQ_W-1:0]    want,
                                                    input logic [SCALAR_W-1:0] have);
    logic [SCALAR_W-1:0] d;
    d = (want[SCALAR_W-1:0] > have) ? want[SCALAR_W-1:0] - have
                                     : have - want[SCALAR_W-1:0];
    return want[REQ_W-1] ? '0 : SQ8_W'(d) * SQ8_W'(d);
  endfunction

  // Buffer wanted (positive request) but the candidate has none.
  function automatic logic absent(input logic [REQ_W-1:0]    want,
                                  input logic [SCALAR_W-1:0] have);
    return !want[REQ_W-1] && (want[SCALAR_W-1:0] != '0) && (have == '0);
  endfunction

endpackage

/* design/fbcbm_intf.sv */
// ----------------------------------------------------------------------------
// fbcbm channel interfaces
// Valid/ready channels for candidates, results and register writes.
// ----------------------------------------------------------------------------
interface fbcbm_cand_if import fbcbm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COLOR_W-1:0]  cand_color;
  logic [ACCUM_W-1:0]  cand_accum;
  logic [SCALAR_W-1:0] cand_alpha;
  logic [SCALAR_W-1:0] cand_depth;
  logic [SCALAR_W-1:0] cand_stencil;
  logic [SCALAR_W-1:0] cand_samples;
  logic [SCALAR_W-1:0] cand_aux;
  logic [FLAGS_W-1:0]  cand_flags;
  logic                last_candidate;

  modport source (
    output valid, cand_color, cand_accum, cand_alpha, cand_depth, cand_stencil,
           cand_samples, cand_aux, cand_flags, last_candidate,
    input  ready
  );
  modport sink (
    input  valid, cand_color, cand_accum, cand_alpha, cand_depth, cand_stencil,
           cand_samples, cand_aux, cand_flags, last_candidate,
    output ready
  );
endinterface

interface fbcbm_res_if import fbcbm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] best_index;
  logic             found;

  modport source (output valid, best_index, found, input ready);
  modport sink (input valid, best_index, found, output ready);
endinterface

interface fbcbm_cfg_if import fbcbm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/fbcbm_cfg.sv */
// ----------------------------------------------------------------------------
// fbcbm_cfg
// Register file holding the desired framebuffer format.
// ----------------------------------------------------------------------------
module fbcbm_cfg import fbcbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbcbm_cfg_if.sink   cfg_i,
  output cfg_t        desired_o
);

  cfg_t regs_q;
  cfg_t regs_d;

  assign cfg_i.ready = 1'b1;
  assign desired_o   = regs_q;

  always_comb begin
    regs_d = regs_q;
    if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.index))
        REG_COLOR:   regs_d.color   = cfg_i.data[COLOR_W-1:0];
        REG_ACCUM:   regs_d.accum   = cfg_i.data[ACCUM_W-1:0];
        REG_ALPHA:   regs_d.alpha   = cfg_i.data[REQ_W-1:0];
        REG_DEPTH:   regs_d.depth   = cfg_i.data[REQ_W-1:0];
        REG_STENCIL: regs_d.stencil = cfg_i.data[REQ_W-1:0];
        REG_SAMPLES: regs_d.samples = cfg_i.data[REQ_W-1:0];
        REG_AUX:     regs_d.aux     = cfg_i.data[REQ_W-1:0];
        REG_FLAGS:   regs_d.flags   = cfg_i.data[FLAGS_W-1:0];
        default:     regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.color   <= COLOR_W'(24'h080808);
      regs_q.accum   <= '0;
      regs_q.alpha   <= REQ_W'(8);
      regs_q.depth   <= REQ_W'(24);
      regs_q.stencil <= REQ_W'(8);
      regs_q.samples <= '0;
      regs_q.aux     <= '0;
      regs_q.flags   <= FLAGS_W'(3'b010);
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

/* design/fbcbm_score.sv */
// ----------------------------------------------------------------------------
// fbcbm_score
// Input register and cost computation for one candidate per cycle unless the output stalls.
// ----------------------------------------------------------------------------
module fbcbm_score import fbcbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbcbm_cand_if.sink  cand_i,
  input  cfg_t        desired_i,
  output logic        sc_valid_o,
  input  logic        sc_ready_i,
  output score_t      sc_o
);

  logic   s1_valid_q;
  cand_t  s1_q;
  logic   s1_go;
  logic   sc_valid_q;
  score_t sc_q;
  score_t sc_d;

  logic [SCALAR_W-1:0]     aux_want;
  logic [MISS_W-1:0]       shortfall;
  logic [SQ_W-1:0]         color_term [3];
  logic [SQ_W-1:0]         accum_term [4];
  logic [EXTRA_COST_W-1:0] accum_sum;

  // Stage one moves on when the score register is empty or being drained.
  assign s1_go        = s1_valid_q && (!sc_valid_q || sc_ready_i);
  assign cand_i.ready = !s1_valid_q || s1_go;
  assign sc_valid_o   = sc_valid_q;
  assign sc_o         = sc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      sc_valid_q <= 1'b0;
    end else begin
      if (cand_i.ready) begin
        s1_valid_q <= cand_i.valid;
      end
      if (!sc_valid_q || sc_ready_i) begin
        sc_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cand_i.valid && cand_i.ready) begin
      s1_q.color   <= cand_i.cand_color;
      s1_q.accum   <= cand_i.cand_accum;
      s1_q.alpha   <= cand_i.cand_alpha;
      s1_q.depth   <= cand_i.cand_depth;
      s1_q.stencil <= cand_i.cand_stencil;
      s1_q.samples <= cand_i.cand_samples;
      s1_q.aux     <= cand_i.cand_aux;
      s1_q.flags   <= cand_i.cand_flags;
      s1_q.last    <= cand_i.last_candidate;
    end
    if (s1_go) begin
      sc_q <= sc_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      color_term[k] = packed_term(desired_i.color[k*CHANNEL_BITS +: CHANNEL_BITS],
                                  s1_q.color[k*CHANNEL_BITS +: CHANNEL_BITS]);
    end
    for (int k = 0; k < 4; k++) begin
      accum_term[k] = packed_term(desired_i.accum[k*CHANNEL_BITS +: CHANNEL_BITS],
                                  s1_q.accum[k*CHANNEL_BITS +: CHANNEL_BITS]);
    end
    accum_sum = EXTRA_COST_W'(accum_term[0]) + EXTRA_COST_W'(accum_term[1])
              + EXTRA_COST_W'(accum_term[2]) + EXTRA_COST_W'(accum_term[3]);

    aux_want  = desired_i.aux[SCALAR_W-1:0];
    shortfall = (!desired_i.aux[REQ_W-1] && (aux_want > s1_q.aux))
              ? MISS_W'(aux_want - s1_q.aux) : '0;

    sc_d.skip = (desired_i.flags[FLAG_STEREO] && !s1_q.flags[FLAG_STEREO])
             || (desired_i.flags[FLAG_DOUBLE] != s1_q.flags[FLAG_DOUBLE]);

    sc_d.missing = MISS_W'(absent(desired_i.alpha, s1_q.alpha))
                 + MISS_W'(absent(desired_i.depth, s1_q.depth))
                 + MISS_W'(absent(desired_i.stencil, s1_q.stencil))
                 + MISS_W'(absent(desired_i.samples, s1_q.samples))
                 + shortfall;

    sc_d.color = COLOR_COST_W'(color_term[0]) + COLOR_COST_W'(color_term[1])
               + COLOR_COST_W'(color_term[2]);

    sc_d.extra = EXTRA_COST_W'(scalar_term(desired_i.alpha, s1_q.alpha))
               + EXTRA_COST_W'(scalar_term(desired_i.depth, s1_q.depth))
               + EXTRA_COST_W'(scalar_term(desired_i.stencil, s1_q.stencil))
               + EXTRA_COST_W'(scalar_term(desired_i.samples, s1_q.samples))
               + accum_sum
               + EXTRA_COST_W'(desired_i.flags[FLAG_SRGB] && !s1_q.flags[FLAG_SRGB]);

    sc_d.last = s1_q.last;
  end

endmodule

/* design/fbcbm_select.sv */
// ----------------------------------------------------------------------------
// fbcbm_select
// Keeps the best candidate so far and issues the result on the last item.
// ----------------------------------------------------------------------------
module fbcbm_select import fbcbm_pkg::*; #(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        sc_valid_i,
  output logic        sc_ready_o,
  input  score_t      sc_i,
  fbcbm_res_if.source res_o
);

  localparam int CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int POS_W = $clog2(MAX_CANDIDATES);

  logic [CNT_W-1:0]        cnt_q;
  logic                    have_q;
  logic [MISS_W-1:0]       best_miss_q;
  logic [COLOR_COST_W-1:0] best_color_q;
  logic [EXTRA_COST_W-1:0] best_extra_q;
  logic [POS_W-1:0]        best_pos_q;
  logic                    res_valid_q;
  logic [IDX_W-1:0]        res_index_q;
  logic                    res_found_q;

  logic             go;
  logic             in_range;
  logic             better;
  logic             take;
  logic             have_n;
  logic [POS_W-1:0] pos_n;

  // Only an item that produces a result needs room in the output register.
  assign sc_ready_o = !sc_i.last || !res_valid_q || res_o.ready;
  assign go         = sc_valid_i && sc_ready_o;

  assign in_range = cnt_q < CNT_W'(MAX_CANDIDATES);
  assign better   = (sc_i.missing < best_miss_q)
                 || ((sc_i.missing == best_miss_q)
                     && ((sc_i.color < best_color_q)
                         || ((sc_i.color == best_color_q) && (sc_i.extra < best_extra_q))));
  assign take     = in_range && !sc_i.skip && (!have_q || better);
  assign have_n   = have_q || take;
  assign pos_n    = take ? POS_W'(cnt_q) : best_pos_q;

  assign res_o.valid      = res_valid_q;
  assign res_o.best_index = res_index_q;
  assign res_o.found      = res_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      have_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (go) begin
        if (sc_i.last) begin
          cnt_q  <= '0;
          have_q <= 1'b0;
        end else begin
          have_q <= have_n;
          if (in_range) begin
            cnt_q <= cnt_q + CNT_W'(1);
          end
        end
      end
      if (go && sc_i.last) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go && take) begin
      best_miss_q  <= sc_i.missing;
      best_color_q <= sc_i.color;
      best_extra_q <= sc_i.extra;
      best_pos_q   <= pos_n;
    end
    if (go && sc_i.last) begin
      res_index_q <= have_n ? IDX_W'(pos_n) : '0;
      res_found_q <= have_n;
    end
  end

endmodule

/* design/framebuffer_config_best_match.sv */
// ----------------------------------------------------------------------------
// framebuffer_config_best_match
// Streaming closest-match selector for candidate framebuffer formats.
// ----------------------------------------------------------------------------
// Candidate formats arrive up to one item per clock on cand_i and are scored
// against the desired format held in eight registers written through cfg_i
// (index 0 color, 1 accum, 2 alpha, 3 depth, 4 stencil, 5 samples, 6 aux,
// 7 flags). A candidate that lacks requested stereo or whose double-buffer
// bit differs from the request is skipped. Every other candidate gets a
// missing-buffer cost, a color cost and an extra cost, and the smallest of
// these compared in that order is kept, with ties going to the earlier
// candidate. The item marked last_candidate produces one result on res_o
// with the winner's list position and a found flag, and the search restarts
// at position zero. Items past MAX_CANDIDATES in one list are never kept.
// The block sustains one item per clock unless a waiting result stalls it.
// An item passes through an input register, a scoring stage of eleven
// 8x8 squarers and their adder trees that writes a score register, and a
// compare-and-keep stage that writes the result register. cand_i.ready drops
// only when a result waits in the result register and both stages behind it
// are occupied. Register writes are accepted every cycle; they are meant to
// happen only while no list is in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module framebuffer_config_best_match import fbcbm_pkg::*; #(
  parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fbcbm_cfg_if.sink   cfg_i,
  fbcbm_cand_if.sink  cand_i,
  fbcbm_res_if.source res_o
);

  cfg_t   desired;
  logic   sc_valid;
  logic   sc_ready;
  score_t sc;

  // Desired-format registers.
  fbcbm_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_i),
    .desired_o (desired)
  );

  // Input register and the three cost sums.
  fbcbm_score u_score (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cand_i     (cand_i),
    .desired_i  (desired),
    .sc_valid_o (sc_valid),
    .sc_ready_i (sc_ready),
    .sc_o       (sc)
  );

  // Best-so-far tracking, position counter and result register.
  fbcbm_select #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_select (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sc_valid_i (sc_valid),
    .sc_ready_o (sc_ready),
    .sc_i       (sc),
    .res_o      (res_o)
  );

  // A result with nothing found always reports position zero.
  `ASSERT_CLK(a_notfound_zero, clk_i, rst_ni, (res_o.valid && !res_o.found) |-> (res_o.best_index == '0), "result without a match carries a nonzero index")

  // A new result only follows a last item leaving the scoring stage.
  `ASSERT_CLK(a_result_after_last, clk_i, rst_ni, $rose(res_o.valid) |-> $past(sc_valid && sc_ready && sc.last), "result appeared without a last item")

  // The input stalls only when the scoring stage is full as well.
  `ASSERT_NEVER(a_stall_only_when_full, clk_i, rst_ni, !cand_i.ready && !sc_valid, "input stalled with an empty scoring stage")

endmodule
